[sv/gwmc_pkg.sv]
// ----------------------------------------------------------------------------
// gwmc_pkg
// Constants, micro-op types and the control store of the guard word sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package gwmc_pkg;

	localparam int unsigned MAX_TRIES = 64;
	localparam int unsigned TRY_W     = (MAX_TRIES > 1) ? $clog2(MAX_TRIES) : 1;

	localparam logic [31:0] LCG_MUL     = 32'd1664525;
	localparam logic [31:0] LCG_ADD     = 32'd1013904223;
	localparam logic [31:0] SIG_PRIME   = 32'd1445174711;
	localparam logic [31:0] FAIR_HIGH   = 32'hFFFF_0000;
	localparam logic [31:0] FAIR_LOW    = 32'h0000_FFFF;
	localparam logic [63:0] POISON_WORD = 64'h0000_000D_EADB_0D1F;

	typedef enum logic [1:0] {
		REQ_MAKE   = 2'd0,
		REQ_CHECK  = 2'd1,
		REQ_POISON = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	// datapath action of one step
	typedef enum logic [2:0] {
		ALU_NOP,
		ALU_SUM,
		ALU_MUL_SIG,
		ALU_MUL_LCG,
		ALU_ADV
	} alu_t;

	// jump condition
	typedef enum logic [2:0] {
		CND_NEXT,
		CND_ALWAYS,
		CND_CHIRP_BAD,
		CND_SIG_GOOD,
		CND_TRY_LAST
	} cnd_t;

	// result issued by a step; any value but EMT_NONE ends the program
	typedef enum logic [2:0] {
		EMT_NONE,
		EMT_MADE,
		EMT_GIVEUP,
		EMT_CHECK,
		EMT_POISON,
		EMT_ZERO
	} emt_t;

	typedef logic [3:0] pc_t;

	typedef struct packed {
		alu_t alu;
		cnd_t cnd;
		pc_t  tgt;
		emt_t emt;
	} uop_t;

	localparam pc_t PC_MK_SUM  = 4'd0;
	localparam pc_t PC_MK_SIG  = 4'd1;
	localparam pc_t PC_MK_TEST = 4'd2;
	localparam pc_t PC_MK_LCG  = 4'd3;
	localparam pc_t PC_MK_ADV  = 4'd4;
	localparam pc_t PC_MK_OUT  = 4'd5;
	localparam pc_t PC_MK_FAIL = 4'd6;
	localparam pc_t PC_CK_SUM  = 4'd7;
	localparam pc_t PC_CK_SIG  = 4'd8;
	localparam pc_t PC_CK_OUT  = 4'd9;
	localparam pc_t PC_PZ_OUT  = 4'd10;
	localparam pc_t PC_NIL_OUT = 4'd11;

	function automatic uop_t ucode_rom(input pc_t pc);
		uop_t u;
		u = '{alu: ALU_NOP, cnd: CND_NEXT, tgt: PC_MK_SUM, emt: EMT_ZERO};
		unique case (pc)
			PC_MK_SUM:  u = '{alu: ALU_SUM,     cnd: CND_CHIRP_BAD, tgt: PC_MK_LCG,  emt: EMT_NONE};
			PC_MK_SIG:  u = '{alu: ALU_MUL_SIG, cnd: CND_NEXT,      tgt: PC_MK_SUM,  emt: EMT_NONE};
			PC_MK_TEST: u = '{alu: ALU_NOP,     cnd: CND_SIG_GOOD,  tgt: PC_MK_OUT,  emt: EMT_NONE};
			PC_MK_LCG:  u = '{alu: ALU_MUL_LCG, cnd: CND_TRY_LAST,  tgt: PC_MK_FAIL, emt: EMT_NONE};
			PC_MK_ADV:  u = '{alu: ALU_ADV,     cnd: CND_ALWAYS,    tgt: PC_MK_SUM,  emt: EMT_NONE};
			PC_MK_OUT:  u = '{alu: ALU_NOP,     cnd: CND_NEXT,      tgt: PC_MK_SUM,  emt: EMT_MADE};
			PC_MK_FAIL: u = '{alu: ALU_NOP,     cnd: CND_NEXT,      tgt: PC_MK_SUM,  emt: EMT_GIVEUP};
			PC_CK_SUM:  u = '{alu: ALU_SUM,     cnd: CND_NEXT,      tgt: PC_MK_SUM,  emt: EMT_NONE};
			PC_CK_SIG:  u = '{alu: ALU_MUL_SIG, cnd: CND_NEXT,      tgt: PC_MK_SUM,  emt: EMT_NONE};
			PC_CK_OUT:  u = '{alu: ALU_NOP,     cnd: CND_NEXT,      tgt: PC_MK_SUM,  emt: EMT_CHECK};
			PC_PZ_OUT:  u = '{alu: ALU_NOP,     cnd: CND_NEXT,      tgt: PC_MK_SUM,  emt: EMT_POISON};
			default:    u = '{alu: ALU_NOP,     cnd: CND_NEXT,      tgt: PC_MK_SUM,  emt: EMT_ZERO};
		endcase
		return u;
	endfunction

	function automatic logic is_fair(input logic [31:0] v);
		return (v > FAIR_LOW) && (v < FAIR_HIGH);
	endfunction

	function automatic logic [31:0] fold(input logic [63:0] p);
		return p[31:0] ^ p[63:32];
	endfunction

endpackage

`default_nettype wire

[sv/guard_word_make_and_check.sv]
// ----------------------------------------------------------------------------
// guard_word_make_and_check
// Makes, checks and poisons 64-bit guard words under a small microprogram.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req_type, seed, salt, stored_word) is taken at a rising edge
//   with start high and busy low. busy stays high until the result is issued.
//   The result (guard_word, check_failed, gave_up) is on its ports for exactly
//   one cycle with done high; the receiver cannot stall it. busy falls in the
//   same cycle done rises, so the next request can be taken then.
//   Poison and unused codes issue their result in their first step; a check
//   runs sum, signature and output. A make try runs sum, then signature and
//   test if the chirp is fair, then output if the signature is fair, else the
//   chirp step and advance, and gives up after the last of MAX_TRIES tries.
//   The rate is set by the single shared 32x32 multiplier, which computes the
//   signature product and the chirp step in turn, one micro-op per cycle.
//   checks_disabled is to be written through cfg_we/cfg_wdata while idle;
//   not enforced here. Reset clears the sequencer, strobe and checks_disabled.
// ----------------------------------------------------------------------------
`default_nettype none

module guard_word_make_and_check
	import gwmc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_wdata,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  req_type,
	input  wire logic [31:0] seed,
	input  wire logic [31:0] salt,
	input  wire logic [63:0] stored_word,
	output logic             done,
	output logic [63:0]      guard_word,
	output logic             check_failed,
	output logic             gave_up
);

	logic             cfg_dis_q;
	logic             busy_q;
	logic             done_q;
	pc_t              pc_q;
	logic [TRY_W-1:0] tries_q;

	logic [31:0] chirp_q;
	logic [31:0] salt_q;
	logic [31:0] wsig_q;
	logic [31:0] opa_q;
	logic [63:0] prod_q;
	logic [63:0] guard_q;
	logic        failed_q;
	logic        gave_q;

	uop_t        uop;
	logic        jump;
	logic [31:0] mul_a;
	logic [31:0] mul_b;
	logic [63:0] mul_p;
	logic [31:0] sig;
	logic        accept;
	pc_t         entry;

	assign accept = start && !busy_q;
	assign uop    = ucode_rom(pc_q);
	assign sig    = fold(prod_q);

	always_comb begin
		unique case (req_t'(req_type))
			REQ_MAKE:   entry = PC_MK_SUM;
			REQ_CHECK:  entry = PC_CK_SUM;
			REQ_POISON: entry = PC_PZ_OUT;
			default:    entry = PC_NIL_OUT;
		endcase
	end

	always_comb begin
		unique case (uop.cnd)
			CND_ALWAYS:    jump = 1'b1;
			CND_CHIRP_BAD: jump = !is_fair(chirp_q);
			CND_SIG_GOOD:  jump = is_fair(sig);
			CND_TRY_LAST:  jump = (tries_q == TRY_W'(MAX_TRIES - 1));
			default:       jump = 1'b0;
		endcase
	end

	// one multiplier serves both the signature and the chirp step
	assign mul_a = (uop.alu == ALU_MUL_SIG) ? opa_q : chirp_q;
	assign mul_b = (uop.alu == ALU_MUL_SIG) ? SIG_PRIME : LCG_MUL;
	assign mul_p = {32'b0, mul_a} * {32'b0, mul_b};

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_dis_q <= 1'b0;
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			pc_q      <= PC_MK_SUM;
			tries_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				cfg_dis_q <= cfg_wdata;
			end
			if (accept) begin
				busy_q  <= 1'b1;
				pc_q    <= entry;
				tries_q <= '0;
			end else if (busy_q) begin
				if (uop.emt != EMT_NONE) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else if (jump) begin
					pc_q <= uop.tgt;
				end else begin
					pc_q <= pc_q + 4'd1;
				end
				if (uop.alu == ALU_ADV) begin
					tries_q <= tries_q + 1'b1;
				end
			end
		end
	end

	// datapath and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			chirp_q <= (req_t'(req_type) == REQ_MAKE) ? seed : stored_word[31:0];
			salt_q  <= salt;
			wsig_q  <= stored_word[63:32];
		end else if (busy_q) begin
			case (uop.alu)
				ALU_SUM:     opa_q   <= chirp_q + salt_q;
				ALU_MUL_SIG: prod_q  <= mul_p;
				ALU_MUL_LCG: prod_q  <= mul_p;
				ALU_ADV:     chirp_q <= prod_q[31:0] + LCG_ADD;
				default:     ;
			endcase
			case (uop.emt)
				EMT_MADE: begin
					guard_q  <= {sig, chirp_q};
					failed_q <= 1'b0;
					gave_q   <= 1'b0;
				end
				EMT_GIVEUP: begin
					guard_q  <= '0;
					failed_q <= 1'b0;
					gave_q   <= 1'b1;
				end
				EMT_CHECK: begin
					guard_q  <= '0;
					failed_q <= !cfg_dis_q &&
						!(is_fair(chirp_q) && is_fair(wsig_q) && (wsig_q == sig));
					gave_q   <= 1'b0;
				end
				EMT_POISON: begin
					guard_q  <= POISON_WORD;
					failed_q <= 1'b0;
					gave_q   <= 1'b0;
				end
				EMT_ZERO: begin
					guard_q  <= '0;
					failed_q <= 1'b0;
					gave_q   <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	assign busy         = busy_q;
	assign done         = done_q;
	assign guard_word   = guard_q;
	assign check_failed = failed_q;
	assign gave_up      = gave_q;

`ifndef SYNTH
	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result issued without a request in flight");

	a_accept_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not raise busy");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(gave_up && check_failed))
		else $error("give-up and check failure both set");

	a_giveup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && gave_up) |-> (guard_word == 64'd0))
		else $error("give-up result carries a nonzero word");
`endif

endmodule

`default_nettype wire
